// ----- design/score_trend_fit_forecast_assert.svh -----
// ----------------------------------------------------------------------------
// score trend fit forecast assertion macros
// wrappers that keep concurrent checks out of builds that exclude them
// ----------------------------------------------------------------------------
`ifndef SCORE_TREND_FIT_FORECAST_ASSERT_SVH
`define SCORE_TREND_FIT_FORECAST_ASSERT_SVH
`ifndef NO_ASSERTIONS
// check under reset gating
`define STFF_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");
// check at every edge, reset included
`define STFF_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");
`else
`define STFF_ASSERT(name, clk, rst, prop)
`define STFF_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

// ----- design/stff_pkg.sv -----
// ----------------------------------------------------------------------------
// stff_pkg
// shared widths, codes and command/status types of the trend fit block
// ----------------------------------------------------------------------------
package stff_pkg;

  localparam int MAX_SAMPLES = 64;
  localparam int MAX_HORIZON = 16;

  localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
  localparam int SCORE_W = 7;
  localparam int HOR_W   = 5;
  localparam int STEP_W  = $clog2(MAX_HORIZON + 1);
  localparam int SY_W    = 13;
  localparam int SXY_W   = 18;
  localparam int SX_W    = 11;
  localparam int SXX_W   = 17;
  localparam int MUL_A_W = 13;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int DIFF_W  = PROD_W + 1;
  localparam int NUM_W   = 41;
  localparam int MAG_W   = NUM_W - 1;
  localparam int DIV_ITER_W = $clog2(MAG_W);
  localparam int DEN_W   = 21;
  localparam int Q_W     = 20;
  localparam int SLOPE_W = 18;
  localparam int ICPT_W  = 20;
  localparam int PCT_W   = 7;
  localparam int CODE_W  = 2;
  localparam int IDX_W   = 7;
  localparam int VAL_W   = 27;
  localparam int SS_W    = 15;
  localparam int NUM_MUL = 6;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 80;

  localparam logic [SCORE_W-1:0] SCORE_MAX = 7'd100;
  // floor(v/1000) for 0 < v < 100000 as (v * RECIP) >> RECIP_SH
  localparam int RECIP    = 67109;
  localparam int RECIP_SH = 26;
  localparam int PRED_IN_W = 17;
  // floor(s/3) for s <= 300 as (s * 171) >> 9
  localparam int THIRD_MUL = 171;
  localparam int THIRD_SH  = 9;

  localparam logic KIND_SUMMARY  = 1'b0;
  localparam logic KIND_FORECAST = 1'b1;

  localparam logic [CODE_W-1:0] TREND_STABLE    = 2'd0;
  localparam logic [CODE_W-1:0] TREND_IMPROVING = 2'd1;
  localparam logic [CODE_W-1:0] TREND_DECLINING = 2'd2;
  localparam logic [CODE_W-1:0] VERDICT_STABLE  = 2'd0;
  localparam logic [CODE_W-1:0] VERDICT_MONITOR = 2'd1;
  localparam logic [CODE_W-1:0] VERDICT_LIKELY  = 2'd2;
  localparam logic [CODE_W-1:0] RISK_LOW        = 2'd0;
  localparam logic [CODE_W-1:0] RISK_MEDIUM     = 2'd1;
  localparam logic [CODE_W-1:0] RISK_HIGH       = 2'd2;

  typedef enum logic [2:0] {
    MUL_N_SXY,
    MUL_SX_SY,
    MUL_N_SXX,
    MUL_SX_SX,
    MUL_SY_SXX,
    MUL_SX_SXY
  } mul_sel_t;

  typedef struct packed {
    logic              acc;
    logic              clear;
    logic              mul_en;
    mul_sel_t          mul_sel;
    logic              diff;
    logic              scale;
    logic              div_start;
    logic              div_icpt;
    logic              ld_slope;
    logic              ld_icpt;
    logic              sum_load;
    logic              fc_val;
    logic              fc_pct;
    logic              fc_load;
    logic              last;
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic             few_points;
    logic             div_done;
    logic             out_busy;
    logic [HOR_W-1:0] horizon;
  } status_t;

endpackage

// ----- design/stff_div.sv -----
// ----------------------------------------------------------------------------
// stff_div
// signed by unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module stff_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [stff_pkg::NUM_W-1:0] num,
  input  logic        [stff_pkg::DEN_W-1:0] den,
  output logic                             busy,
  output logic                             done,
  output logic signed [stff_pkg::Q_W-1:0]   quot
);

  logic [stff_pkg::DIV_ITER_W-1:0] iter;
  logic [stff_pkg::DEN_W-1:0]  rem;
  logic [stff_pkg::MAG_W-1:0]  dq;
  logic                        neg;
  logic [stff_pkg::NUM_W-1:0]  num_abs;
  logic [stff_pkg::DEN_W:0]    trial;
  logic                        fits;

  assign num_abs = num[stff_pkg::NUM_W-1] ? -num : num;
  assign trial   = {rem, dq[stff_pkg::MAG_W-1]};
  assign fits    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= '0;
        rem  <= '0;
        dq   <= num_abs[stff_pkg::MAG_W-1:0];
        neg  <= num[stff_pkg::NUM_W-1];
      end else if (busy) begin
        rem  <= fits ? stff_pkg::DEN_W'(trial - {1'b0, den})
                     : trial[stff_pkg::DEN_W-1:0];
        dq   <= {dq[stff_pkg::MAG_W-2:0], fits};
        iter <= iter + 1'b1;
        if (iter == stff_pkg::DIV_ITER_W'(stff_pkg::MAG_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = neg ? -$signed(dq[stff_pkg::Q_W-1:0]) : $signed(dq[stff_pkg::Q_W-1:0]);

endmodule

// ----- design/stff_ctrl.sv -----
// ----------------------------------------------------------------------------
// stff_ctrl
// sequencer for accumulation, line fit and forecast emission
// ----------------------------------------------------------------------------
module stff_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tlast,
  output logic              s_tready,
  input  stff_pkg::status_t st,
  output stff_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_DIFF, S_SCALE, S_DIVS, S_DIVS_W, S_DIVI, S_DIVI_W,
    S_SUMM, S_FC_VAL, S_FC_PCT, S_FC_OUT, S_DONE
  } state_t;

  state_t                      state;
  stff_pkg::mul_sel_t          msel;
  logic [stff_pkg::STEP_W-1:0] step;
  logic                        fc_last;

  assign s_tready = (state == S_IDLE);
  assign fc_last  = ({1'b0, step} + 1'b1) == {1'b0, st.horizon};

  always_comb begin
    cmd         = '0;
    cmd.mul_sel = msel;
    cmd.step    = step;
    case (state)
      S_IDLE:   cmd.acc = s_tvalid;
      S_MUL:    cmd.mul_en = 1'b1;
      S_DIFF:   cmd.diff = 1'b1;
      S_SCALE:  cmd.scale = 1'b1;
      S_DIVS:   cmd.div_start = 1'b1;
      S_DIVS_W: cmd.ld_slope = st.div_done;
      S_DIVI: begin
        cmd.div_start = 1'b1;
        cmd.div_icpt  = 1'b1;
      end
      S_DIVI_W: cmd.ld_icpt = st.div_done;
      S_SUMM: begin
        cmd.sum_load = !st.out_busy;
        cmd.last     = (st.horizon == '0);
      end
      S_FC_VAL: cmd.fc_val = 1'b1;
      S_FC_PCT: cmd.fc_pct = 1'b1;
      S_FC_OUT: begin
        cmd.fc_load = !st.out_busy;
        cmd.last    = fc_last;
      end
      S_DONE:   cmd.clear = 1'b1;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      msel  <= stff_pkg::MUL_N_SXY;
      step  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tlast) begin
            state <= S_MUL;
            msel  <= stff_pkg::MUL_N_SXY;
          end
        end
        S_MUL: begin
          if (msel == stff_pkg::MUL_SX_SXY) begin
            state <= S_DIFF;
          end else begin
            msel <= stff_pkg::mul_sel_t'(msel + 1'b1);
          end
        end
        S_DIFF:  state <= S_SCALE;
        S_SCALE: state <= st.few_points ? S_SUMM : S_DIVS;
        S_DIVS:  state <= S_DIVS_W;
        S_DIVS_W: begin
          if (st.div_done) state <= S_DIVI;
        end
        S_DIVI:  state <= S_DIVI_W;
        S_DIVI_W: begin
          if (st.div_done) state <= S_SUMM;
        end
        S_SUMM: begin
          if (!st.out_busy) begin
            step  <= '0;
            state <= (st.horizon == '0) ? S_DONE : S_FC_VAL;
          end
        end
        S_FC_VAL: state <= S_FC_PCT;
        S_FC_PCT: state <= S_FC_OUT;
        S_FC_OUT: begin
          if (!st.out_busy) begin
            step  <= step + 1'b1;
            state <= fc_last ? S_DONE : S_FC_VAL;
          end
        end
        S_DONE:  state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/stff_dp.sv -----
// ----------------------------------------------------------------------------
// stff_dp
// accumulators, shared multiplier, divider, scoring logic and result register
// ----------------------------------------------------------------------------
`include "score_trend_fit_forecast_assert.svh"

module stff_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  stff_pkg::cmd_t                       cmd,
  output stff_pkg::status_t                    st,
  input  logic [stff_pkg::SCORE_W-1:0]         score,
  input  logic                                 cfg_valid,
  input  logic [stff_pkg::HOR_W-1:0]           cfg_data,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [stff_pkg::OUT_TDATA_W-1:0]     m_tdata,
  output logic                                 m_tuser,
  output logic                                 m_tlast
);

  // accumulators
  logic [stff_pkg::CNT_W-1:0]   cnt;
  logic [stff_pkg::SY_W-1:0]    sy;
  logic [stff_pkg::SXY_W-1:0]   sxy;
  logic [stff_pkg::SX_W-1:0]    sx;
  logic [stff_pkg::SXX_W-1:0]   sxx;
  logic [stff_pkg::SCORE_W-1:0] rec [3];
  logic [stff_pkg::SCORE_W-1:0] s_sat;
  logic [stff_pkg::HOR_W-1:0]   horizon;

  // fit
  logic [stff_pkg::PROD_W-1:0]        prod [stff_pkg::NUM_MUL];
  logic [stff_pkg::MUL_A_W-1:0]       mul_a;
  logic [stff_pkg::MUL_B_W-1:0]       mul_b;
  logic signed [stff_pkg::DIFF_W-1:0] snum, inum, dend;
  logic signed [stff_pkg::NUM_W-1:0]  snum_k, inum_k, snum_x, inum_x;
  logic signed [stff_pkg::NUM_W-1:0]  snum_k_r, inum_k_r;
  logic signed [stff_pkg::SLOPE_W-1:0] slope;
  logic signed [stff_pkg::ICPT_W-1:0]  icpt;
  logic                               div_busy, div_done;
  logic signed [stff_pkg::Q_W-1:0]    quot;

  // variance of the last three scores
  logic [8:0]                   tsum;
  logic [7:0]                   mean;
  logic signed [8:0]            d0, d1, d2;
  logic [stff_pkg::SS_W-1:0]    ss;
  logic [7:0]                   conf, regp;

  // forecast
  logic [stff_pkg::IDX_W-1:0]          at;
  logic signed [stff_pkg::VAL_W-1:0]   val;
  logic [stff_pkg::PCT_W-1:0]          pct;
  logic [2*stff_pkg::PRED_IN_W-1:0]    pred_prod;
  logic [stff_pkg::CODE_W-1:0]         trend, verdict, risk;
  logic [stff_pkg::OUT_TDATA_W-1:0]    sum_data, fc_data;

  assign s_sat = (score > stff_pkg::SCORE_MAX) ? stff_pkg::SCORE_MAX : score;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      sy      <= '0;
      sxy     <= '0;
      sx      <= '0;
      sxx     <= '0;
      rec     <= '{default: '0};
      horizon <= stff_pkg::HOR_W'(3);
    end else begin
      if (cfg_valid) horizon <= cfg_data;
      if (cmd.clear) begin
        cnt <= '0;
        sy  <= '0;
        sxy <= '0;
        sx  <= '0;
        sxx <= '0;
        rec <= '{default: '0};
      end else if (cmd.acc && (cnt < stff_pkg::CNT_W'(stff_pkg::MAX_SAMPLES))) begin
        sy     <= sy + stff_pkg::SY_W'(s_sat);
        sxy    <= sxy + stff_pkg::SXY_W'(cnt * s_sat);
        sx     <= sx + stff_pkg::SX_W'(cnt);
        sxx    <= sxx + stff_pkg::SXX_W'(cnt * cnt);
        rec[0] <= rec[1];
        rec[1] <= rec[2];
        rec[2] <= s_sat;
        cnt    <= cnt + 1'b1;
      end
    end
  end

  // shared multiplier for the six normal-equation products
  always_comb begin
    case (cmd.mul_sel)
      stff_pkg::MUL_N_SXY: begin
        mul_a = stff_pkg::MUL_A_W'(cnt);
        mul_b = sxy;
      end
      stff_pkg::MUL_SX_SY: begin
        mul_a = stff_pkg::MUL_A_W'(sx);
        mul_b = stff_pkg::MUL_B_W'(sy);
      end
      stff_pkg::MUL_N_SXX: begin
        mul_a = stff_pkg::MUL_A_W'(cnt);
        mul_b = stff_pkg::MUL_B_W'(sxx);
      end
      stff_pkg::MUL_SX_SX: begin
        mul_a = stff_pkg::MUL_A_W'(sx);
        mul_b = stff_pkg::MUL_B_W'(sx);
      end
      stff_pkg::MUL_SY_SXX: begin
        mul_a = sy;
        mul_b = stff_pkg::MUL_B_W'(sxx);
      end
      stff_pkg::MUL_SX_SXY: begin
        mul_a = stff_pkg::MUL_A_W'(sx);
        mul_b = sxy;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // times 1000 as 1024 - 16 - 8
  assign snum_x = stff_pkg::NUM_W'(snum);
  assign inum_x = stff_pkg::NUM_W'(inum);
  assign snum_k = (snum_x <<< 10) - (snum_x <<< 4) - (snum_x <<< 3);
  assign inum_k = (inum_x <<< 10) - (inum_x <<< 4) - (inum_x <<< 3);

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod[cmd.mul_sel] <= mul_a * mul_b;
    if (cmd.diff) begin
      snum <= $signed({1'b0, prod[0]}) - $signed({1'b0, prod[1]});
      dend <= $signed({1'b0, prod[2]}) - $signed({1'b0, prod[3]});
      inum <= $signed({1'b0, prod[4]}) - $signed({1'b0, prod[5]});
    end
    if (cmd.scale) begin
      snum_k_r <= snum_k;
      inum_k_r <= inum_k;
      if (st.few_points) begin
        slope <= '0;
        icpt  <= stff_pkg::ICPT_W'(sy * 10'd1000);
      end
    end
    if (cmd.ld_slope) slope <= quot[stff_pkg::SLOPE_W-1:0];
    if (cmd.ld_icpt)  icpt  <= quot[stff_pkg::ICPT_W-1:0];
  end

  stff_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (cmd.div_icpt ? inum_k_r : snum_k_r),
    .den   (dend[stff_pkg::DEN_W-1:0]),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (quot)
  );

  // mean and squared spread, settled long before the summary is built
  assign tsum = 9'(rec[0]) + 9'(rec[1]) + 9'(rec[2]);
  assign d0   = $signed({2'b0, rec[0]}) - $signed({1'b0, mean});
  assign d1   = $signed({2'b0, rec[1]}) - $signed({1'b0, mean});
  assign d2   = $signed({2'b0, rec[2]}) - $signed({1'b0, mean});

  always_ff @(posedge clk) begin
    mean <= 8'((18'(tsum) * 18'(stff_pkg::THIRD_MUL)) >> stff_pkg::THIRD_SH);
    ss   <= stff_pkg::SS_W'(d0 * d0) + stff_pkg::SS_W'(d1 * d1)
          + stff_pkg::SS_W'(d2 * d2);
  end

  always_comb begin
    conf = 8'd50;
    if (slope > 18'sd500)       conf = conf + 8'd20;
    else if (slope > 18'sd0)    conf = conf + 8'd10;
    else if (slope < -18'sd500) conf = conf - 8'd20;
    else if (slope < 18'sd0)    conf = conf - 8'd10;
    // var < 4, var < 16 and var > 64 on the undivided sum of squares
    if (cnt >= stff_pkg::CNT_W'(3)) begin
      if (ss < stff_pkg::SS_W'(12))       conf = conf + 8'd20;
      else if (ss < stff_pkg::SS_W'(48))  conf = conf + 8'd10;
      else if (ss >= stff_pkg::SS_W'(195)) conf = conf - 8'd10;
    end
    regp = 8'd100 - conf;
    if (slope < -18'sd200) regp = regp + 8'd10;
    if (slope > 18'sd200)  regp = regp - 8'd10;
    if (slope > 18'sd200)       trend = stff_pkg::TREND_IMPROVING;
    else if (slope < -18'sd200) trend = stff_pkg::TREND_DECLINING;
    else                        trend = stff_pkg::TREND_STABLE;
    if (regp >= 8'd40)      verdict = stff_pkg::VERDICT_LIKELY;
    else if (regp >= 8'd20) verdict = stff_pkg::VERDICT_MONITOR;
    else                    verdict = stff_pkg::VERDICT_STABLE;
    if (pct < 7'd60)      risk = stff_pkg::RISK_HIGH;
    else if (pct < 7'd80) risk = stff_pkg::RISK_MEDIUM;
    else                  risk = stff_pkg::RISK_LOW;
  end

  assign at = stff_pkg::IDX_W'(cnt) + stff_pkg::IDX_W'(cmd.step);
  assign pred_prod = val[stff_pkg::PRED_IN_W-1:0]
                   * (2*stff_pkg::PRED_IN_W)'(stff_pkg::RECIP);

  always_ff @(posedge clk) begin
    if (cmd.fc_val) begin
      val <= stff_pkg::VAL_W'(icpt) + stff_pkg::VAL_W'(slope * $signed({1'b0, at}));
    end
    if (cmd.fc_pct) begin
      if (val <= 0)                 pct <= '0;
      else if (val >= 27'sd100000)  pct <= stff_pkg::SCORE_MAX;
      else pct <= stff_pkg::PCT_W'(pred_prod >> stff_pkg::RECIP_SH);
    end
  end

  assign sum_data = {1'b0, 2'b0, 7'b0, 7'b0, stff_pkg::IDX_W'(cnt), verdict, trend,
                     regp[6:0], conf[6:0], icpt, slope};
  assign fc_data  = {1'b0, risk, pct, at, 7'b0, 2'b0, 2'b0, 7'b0, 7'b0,
                     20'b0, 18'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.sum_load || cmd.fc_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (cmd.sum_load) begin
      m_tdata <= sum_data;
      m_tuser <= stff_pkg::KIND_SUMMARY;
      m_tlast <= cmd.last;
    end else if (cmd.fc_load) begin
      m_tdata <= fc_data;
      m_tuser <= stff_pkg::KIND_FORECAST;
      m_tlast <= cmd.last;
    end
  end

  assign st.few_points = cnt < stff_pkg::CNT_W'(2);
  assign st.div_done   = div_done;
  assign st.out_busy   = m_tvalid;
  assign st.horizon    = (horizon > stff_pkg::HOR_W'(stff_pkg::MAX_HORIZON))
                       ? stff_pkg::HOR_W'(stff_pkg::MAX_HORIZON) : horizon;

  `STFF_ASSERT(a_load_empty, clk, rst, (cmd.sum_load || cmd.fc_load) |-> !m_tvalid)
  `STFF_ASSERT(a_acc_div_idle, clk, rst, cmd.acc |-> !div_busy)
  `STFF_ASSERT(a_pred_range, clk, rst, (m_tvalid && m_tuser) |-> (m_tdata[76:70] <= 7'd100))
  `STFF_ASSERT(a_cnt_cap, clk, rst, cnt <= stff_pkg::CNT_W'(stff_pkg::MAX_SAMPLES))

endmodule

// ----- design/score_trend_fit_forecast.sv -----
// ----------------------------------------------------------------------------
// score_trend_fit_forecast
// least-squares trend fit over a score series with a short forecast run
// ----------------------------------------------------------------------------
// scores (0..100, larger values saturate to 100) arrive one per transaction,
// in version order; tlast marks the final score of a series. a score that
// is not last is taken while the block stays idle and ready. only the first
// 64 scores of a series count, later ones are dropped, but a dropped last
// score still starts the fit. the last score triggers the fit: six products
// through one shared multiplier, a scale-by-1000 step, then two 40-step
// serial divisions (slope, then intercept), skipped when fewer than two
// scores are held. one summary transaction follows (tuser 0) and then one
// forecast transaction per horizon step (tuser 1), each computed in the
// multiply and reciprocal stages and delayed while m_tready is low.
// the horizon saturates at 16; with horizon 0 only the summary is sent and
// it carries tlast. no new score is taken until the run is finished.
// configuration is a single register (the forecast horizon, reset 3); the
// user must write it only while the block is idle, unchecked by the block.
// ----------------------------------------------------------------------------
module score_trend_fit_forecast (
  input  logic                                clk,
  input  logic                                rst,
  // score stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [stff_pkg::IN_TDATA_W-1:0]     s_tdata,   // [6:0] score, [7] zero
  input  logic                                s_tlast,   // is_last
  // result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [17:0] slope_milli, [37:18] intercept_milli, [44:38] confidence,
  // [51:45] regression_pct, [53:52] trend_code, [55:54] verdict_code,
  // [62:56] versions_counted, [69:63] forecast_index, [76:70] projected_score,
  // [78:77] risk_code, [79] zero
  output logic [stff_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                                m_tuser,   // result_kind
  output logic                                m_tlast,   // last_result
  // horizon register write
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [stff_pkg::HOR_W-1:0]          cfg_data
);

  stff_pkg::cmd_t    cmd;
  stff_pkg::status_t st;

  // the register is always writable
  assign cfg_ready = 1'b1;

  stff_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  stff_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .score     (s_tdata[stff_pkg::SCORE_W-1:0]),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule
